// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- hw/rtl/rdl_pkg.sv -----
// ----------------------------------------------------------------------------
// rdl_pkg
// Shared types and constants of the ranked detection list.
// ----------------------------------------------------------------------------
package rdl_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int CONF_W         = 16;
    localparam int POS_W          = 16;
    localparam int ID_W           = 4;
    localparam int SLOT_W         = 5;
    localparam int MAXR_W         = 5;
    localparam int DIST_W         = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int MAX_OUT        = 16;

    localparam logic [MAXR_W-1:0] MAX_ROBOTS_RST = 5'd8;
    localparam logic              DEDUP_EN_RST   = 1'b1;
    localparam logic [DIST_W-1:0] DUP_DIST_RST   = 12'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROBOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_DIST   = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic [CONF_W-1:0]       conf;
        logic signed [POS_W-1:0] fx;
        logic signed [POS_W-1:0] fy;
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        py;
        logic signed [POS_W-1:0] hd;
        logic [ID_W-1:0]         id;
    } t_entry;

    typedef struct packed {
        logic cap_in;
        logic ins_cmp;
        logic ins_wr;
        logic dd_init;
        logic row_start;
        logic row_lat;
        logic pair_sq;
        logic pair_cmp;
        logic row_next;
        logic em_init;
        logic em_rd;
        logic em_chk;
        logic em_fin;
        logic rd_sel_j;
    } t_dp_cmd;

    typedef struct packed {
        logic dedup_en;
        logic row_more;
        logic pair_more;
        logic scan_more;
    } t_dp_stat;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_INS_CMP   = 13'b0000000000010,
        S_INS_WR    = 13'b0000000000100,
        S_DD_INIT   = 13'b0000000001000,
        S_DD_ROW    = 13'b0000000010000,
        S_DD_ROWLAT = 13'b0000000100000,
        S_DD_PAIR   = 13'b0000001000000,
        S_DD_SQ     = 13'b0000010000000,
        S_DD_CMP    = 13'b0000100000000,
        S_EM_INIT   = 13'b0001000000000,
        S_EM_SCAN   = 13'b0010000000000,
        S_EM_CHK    = 13'b0100000000000,
        S_EM_FIN    = 13'b1000000000000
    } t_state;

endpackage

// ----- hw/rtl/rdl_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdl_ctrl
// Sequencer for insert, duplicate pass and report pass.
// ----------------------------------------------------------------------------
module rdl_ctrl
    import rdl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_opcode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap_in = 1'b1;
                    if (i_opcode == OP_INSERT) begin
                        n_state = S_INS_CMP;
                    end else if (i_stat.dedup_en) begin
                        n_state = S_DD_INIT;
                    end else begin
                        n_state = S_EM_INIT;
                    end
                end
            end
            S_INS_CMP: begin
                o_cmd.ins_cmp = 1'b1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_DD_INIT: begin
                o_cmd.dd_init = 1'b1;
                n_state = S_DD_ROW;
            end
            S_DD_ROW: begin
                if (i_stat.row_more) begin
                    o_cmd.row_start = 1'b1;
                    n_state = S_DD_ROWLAT;
                end else begin
                    n_state = S_EM_INIT;
                end
            end
            S_DD_ROWLAT: begin
                o_cmd.row_lat = 1'b1;
                n_state = S_DD_PAIR;
            end
            S_DD_PAIR: begin
                if (i_stat.pair_more) begin
                    o_cmd.rd_sel_j = 1'b1;
                    n_state = S_DD_SQ;
                end else begin
                    o_cmd.row_next = 1'b1;
                    n_state = S_DD_ROW;
                end
            end
            S_DD_SQ: begin
                o_cmd.pair_sq = 1'b1;
                n_state = S_DD_CMP;
            end
            S_DD_CMP: begin
                o_cmd.pair_cmp = 1'b1;
                n_state = S_DD_PAIR;
            end
            S_EM_INIT: begin
                o_cmd.em_init = 1'b1;
                n_state = S_EM_SCAN;
            end
            S_EM_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.em_rd = 1'b1;
                    n_state = S_EM_CHK;
                end else begin
                    n_state = S_EM_FIN;
                end
            end
            S_EM_CHK: begin
                o_cmd.em_chk = 1'b1;
                n_state = S_EM_SCAN;
            end
            S_EM_FIN: begin
                o_cmd.em_fin = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/rdl_dp.sv -----
// ----------------------------------------------------------------------------
// rdl_dp
// List storage, insert shifter, distance unit and report buffer.
// ----------------------------------------------------------------------------
module rdl_dp
    import rdl_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  t_entry                  i_new,
    output logic                    o_strobe,
    output logic                    o_is_report,
    output logic                    o_accepted,
    output logic [SLOT_W-1:0]       o_slot,
    output logic                    o_item_valid,
    output t_entry                  o_ent,
    output logic                    o_last
);

    localparam int IDXW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNTW = $clog2(LIST_DEPTH + 1);

    t_entry r_ent [LIST_DEPTH];
    t_entry prev  [LIST_DEPTH];
    t_entry r_new, r_rd, r_pend, r_oe;

    logic [CNTW-1:0]       r_count, r_i, r_j;
    logic [LIST_DEPTH-1:0] r_lt, first_lt;
    logic [MAXR_W-1:0]     r_max, r_taken, r_k, emit_max;
    logic                  r_dden, r_pend_v;
    logic [DIST_W-1:0]     r_dist;
    logic [2*DIST_W-1:0]   r_lim;
    logic signed [POS_W-1:0] r_xi, r_yi;
    logic [31:0]           r_sqx, r_sqy;
    logic                  r_strobe, r_is_rep, r_acc, r_ival, r_last;
    logic [SLOT_W-1:0]     r_slot;

    logic                  found, room, ok, dup;
    logic [CNTW-1:0]       pos, wpos, ncount;
    logic [7:0]            cap2, cap;
    logic [IDXW-1:0]       raddr;
    logic [CNTW+SLOT_W-1:0] wpos_ext;
    logic signed [POS_W:0] dx, dy;
    logic signed [2*POS_W+1:0] px2, py2;
    logic [32:0]           dsum;
    logic                  take;

    // Insert position: first stored entry of strictly lower confidence.
    always_comb begin
        first_lt = r_lt & ~{r_lt[LIST_DEPTH-2:0], 1'b0};
        found    = |r_lt;
        pos      = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            pos = pos | (first_lt[k] ? CNTW'(k) : '0);
        end
        prev[0] = r_ent[0];
        for (int k = 1; k < LIST_DEPTH; k++) begin
            prev[k] = r_ent[k-1];
        end
        cap2     = {2'b00, r_max, 1'b0};
        cap      = (cap2 > 8'(LIST_DEPTH)) ? 8'(LIST_DEPTH) : cap2;
        room     = 8'(r_count) < cap;
        ok       = found || room;
        wpos     = found ? pos : r_count;
        ncount   = (ok && room) ? r_count + 1'b1 : r_count;
        wpos_ext = {{SLOT_W{1'b0}}, wpos};
    end

    assign raddr = i_cmd.rd_sel_j ? r_j[IDXW-1:0] : r_i[IDXW-1:0];

    // Distance of the pair under test.
    assign dx   = {r_xi[POS_W-1], r_xi} - {r_rd.fx[POS_W-1], r_rd.fx};
    assign dy   = {r_yi[POS_W-1], r_yi} - {r_rd.fy[POS_W-1], r_rd.fy};
    assign px2  = dx * dx;
    assign py2  = dy * dy;
    assign dsum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign dup  = dsum < {9'b0, r_lim};

    assign emit_max = (r_max > 5'(MAX_OUT)) ? 5'(MAX_OUT) : r_max;
    assign take     = i_cmd.em_chk && (r_rd.conf != '0);

    always_comb begin
        o_stat.dedup_en  = r_dden;
        o_stat.row_more  = ({1'b0, r_i} + 1'b1) < {1'b0, r_count};
        o_stat.pair_more = r_j < r_count;
        o_stat.scan_more = (r_i < r_count) && (r_taken < emit_max);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_max    <= MAX_ROBOTS_RST;
            r_dden   <= DEDUP_EN_RST;
            r_dist   <= DUP_DIST_RST;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_ROBOTS: r_max  <= i_cfg_data[MAXR_W-1:0];
                    CFG_DEDUP_EN:   r_dden <= i_cfg_data[0];
                    CFG_DUP_DIST:   r_dist <= i_cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.ins_wr) begin
                r_count <= ncount;
            end
            if (i_cmd.em_fin) begin
                r_count <= '0;
            end
            if (i_cmd.em_init) begin
                r_pend_v <= 1'b0;
            end
            if (take) begin
                r_pend_v <= 1'b1;
            end
            r_strobe <= i_cmd.ins_wr || (take && r_pend_v) || i_cmd.em_fin;
        end
    end

    // Payload and counters.
    always_ff @(posedge i_clk) begin
        r_rd <= r_ent[raddr];
        if (i_cmd.cap_in) begin
            r_new <= i_new;
        end
        if (i_cmd.ins_cmp) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_lt[k] <= (CNTW'(k) < r_count) && (r_ent[k].conf < r_new.conf);
            end
        end
        if (i_cmd.ins_wr) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (ok && CNTW'(k) == wpos) begin
                    r_ent[k] <= r_new;
                end else if (found && CNTW'(k) > pos && CNTW'(k) < ncount) begin
                    r_ent[k] <= prev[k];
                end
            end
            r_is_rep <= 1'b0;
            r_acc    <= ok;
            r_slot   <= ok ? wpos_ext[SLOT_W-1:0] : '0;
            r_ival   <= 1'b0;
            r_oe     <= '0;
            r_last   <= 1'b1;
        end
        if (i_cmd.dd_init) begin
            r_lim <= (2*DIST_W)'(r_dist) * (2*DIST_W)'(r_dist);
            r_i   <= '0;
        end
        if (i_cmd.row_start) begin
            r_j <= r_i + 1'b1;
        end
        if (i_cmd.row_lat) begin
            r_xi <= r_rd.fx;
            r_yi <= r_rd.fy;
        end
        if (i_cmd.pair_sq) begin
            r_sqx <= px2[31:0];
            r_sqy <= py2[31:0];
        end
        if (i_cmd.pair_cmp) begin
            if (dup) begin
                r_ent[r_j[IDXW-1:0]].conf <= '0;
            end
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.row_next) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.em_init) begin
            r_i     <= '0;
            r_k     <= '0;
            r_taken <= '0;
        end
        if (i_cmd.em_rd) begin
            r_i <= r_i + 1'b1;
        end
        if (take) begin
            // Release the held survivor; the new one waits for its last mark.
            if (r_pend_v) begin
                r_is_rep <= 1'b1;
                r_acc    <= 1'b0;
                r_slot   <= r_k;
                r_ival   <= 1'b1;
                r_oe     <= r_pend;
                r_last   <= 1'b0;
                r_k      <= r_k + 1'b1;
            end
            r_pend  <= r_rd;
            r_taken <= r_taken + 1'b1;
        end
        if (i_cmd.em_fin) begin
            r_is_rep <= 1'b1;
            r_acc    <= 1'b0;
            r_last   <= 1'b1;
            r_ival   <= r_pend_v;
            r_slot   <= r_pend_v ? r_k : '0;
            r_oe     <= r_pend_v ? r_pend : '0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_is_report  = r_is_rep;
    assign o_accepted   = r_acc;
    assign o_slot       = r_slot;
    assign o_item_valid = r_ival;
    assign o_ent        = r_oe;
    assign o_last       = r_last;

endmodule

// ----- hw/rtl/ranked_detection_list_core.sv -----
// ----------------------------------------------------------------------------
// ranked_detection_list_core
// Bounded top-k detection list kept in falling confidence order.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  request   i_start, i_opcode, i_confidence..     taken when i_start && !o_busy
//  result    o_is_report .. o_last                 one cycle, marked by o_strobe
//  config    i_cfg_we, i_cfg_idx, i_cfg_data       written when i_cfg_we is high
//
//  Insert: the request passes the compare and write states before the
//  registered acknowledgement strobe; rank compare and shift each take one
//  pass over the register file. Finish: with the duplicate pass on, rows
//  and pairs go through one shared read port and one squaring stage before
//  the report pass scans the entries; with it off only the report pass runs.
//  Reset empties the list and loads the register defaults, with no sweep.
//  Results cannot be stalled; o_busy holds off requests until the last one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ranked_detection_list_core
    import rdl_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_opcode,
    input  logic [CONF_W-1:0]         i_confidence,
    input  logic signed [POS_W-1:0]   i_pos_x,
    input  logic signed [POS_W-1:0]   i_pos_y,
    input  logic [POS_W-1:0]          i_pix_x,
    input  logic [POS_W-1:0]          i_pix_y,
    input  logic signed [POS_W-1:0]   i_heading,
    input  logic [ID_W-1:0]           i_ident,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic                      o_strobe,
    output logic                      o_is_report,
    output logic                      o_accepted,
    output logic [SLOT_W-1:0]         o_slot,
    output logic                      o_item_valid,
    output logic [CONF_W-1:0]         o_out_confidence,
    output logic signed [POS_W-1:0]   o_out_x,
    output logic signed [POS_W-1:0]   o_out_y,
    output logic [POS_W-1:0]          o_out_pix_x,
    output logic [POS_W-1:0]          o_out_pix_y,
    output logic signed [POS_W-1:0]   o_out_heading,
    output logic [ID_W-1:0]           o_out_ident,
    output logic                      o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_entry   new_ent, out_ent;

    // Pack the request fields into one list entry.
    assign new_ent = '{conf: i_confidence, fx: i_pos_x, fy: i_pos_y,
                       px: i_pix_x, py: i_pix_y, hd: i_heading, id: i_ident};

    rdl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    rdl_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_new        (new_ent),
        .o_strobe     (o_strobe),
        .o_is_report  (o_is_report),
        .o_accepted   (o_accepted),
        .o_slot       (o_slot),
        .o_item_valid (o_item_valid),
        .o_ent        (out_ent),
        .o_last       (o_last)
    );

    // Unpack the reported entry onto the result ports.
    assign o_out_confidence = out_ent.conf;
    assign o_out_x          = out_ent.fx;
    assign o_out_y          = out_ent.fy;
    assign o_out_pix_x      = out_ent.px;
    assign o_out_pix_y      = out_ent.py;
    assign o_out_heading    = out_ent.hd;
    assign o_out_ident      = out_ent.id;

    // An insert request is acknowledged by o_strobe after the compare and write states.
    `ASSERT_NEXT(a_ins_ack, i_clk, i_rst_n, i_start && !o_busy && (i_opcode == OP_INSERT), ##2 o_strobe, "insert not acknowledged")
    // The final result of a request leaves the block idle.
    `ASSERT_IMPL(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !o_busy, "busy after last result")
    // More results pending keeps requests held off.
    `ASSERT_IMPL(a_more_busy, i_clk, i_rst_n, o_strobe && !o_last, o_busy, "idle before last result")
    // An acknowledgement is always a single, final result.
    `ASSERT_IMPL(a_ack_last, i_clk, i_rst_n, o_strobe && !o_is_report, o_last && !o_item_valid, "bad acknowledgement")

endmodule
